// ===== sv/hbs_pkg.sv =====
// hbs_pkg: shared types, constants and codes of the heartbeat supervisor
// used by heartbeat_supervisor and hbs_ram users; no dependencies
package hbs_pkg;

    // node table size and derived widths
    localparam int NUM_NODES = 32;
    localparam int NODE_W    = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
    localparam int ID_W      = 7;
    localparam int STATE_W   = 8;
    localparam int MS_W      = 16;
    localparam int IVAL_W    = 17;
    localparam int MASTER_W  = 18;
    localparam int ALU_W     = 19;
    localparam int CODE_W    = 32;
    localparam int RAM_W     = MS_W + STATE_W;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_MASTER_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALIVE_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INHIBIT_MASTER  = 2'd2;

    localparam logic [MS_W-1:0]     RST_MASTER_INTERVAL = 16'd250;
    localparam logic [MS_W-1:0]     RST_ALIVE_THRESHOLD = 16'd1000;
    localparam logic [MASTER_W-1:0] MASTER_MAX          = 18'h3ffff;

    // input commands
    typedef enum logic [1:0] {
        CMD_TICK      = 2'd0,
        CMD_HEARTBEAT = 2'd1,
        CMD_ISSUE     = 2'd2,
        CMD_RESPONSE  = 2'd3
    } t_cmd;

    // result event codes
    typedef enum logic [2:0] {
        EV_STATE_CHANGE = 3'd0,
        EV_NODE_TIMEOUT = 3'd1,
        EV_HB_SEEN      = 3'd2,
        EV_MASTER_DUE   = 3'd3,
        EV_REQ_DONE     = 3'd4,
        EV_REQ_TIMEOUT  = 3'd5
    } t_event;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_MADD,
        S_RD,
        S_NODE,
        S_MCMP,
        S_REQ,
        S_HB_RD,
        S_HB_EVAL,
        S_HB_SEEN,
        S_RESP,
        S_FLUSH
    } t_state;

    // one result item
    typedef struct packed {
        t_event              evt;
        logic [ID_W-1:0]     node;
        logic [STATE_W-1:0]  st;
        logic [IVAL_W-1:0]   ival;
        logic [CODE_W-1:0]   code;
    } t_result;

endpackage

// ===== sv/hbs_ram.sv =====
// hbs_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
module hbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/heartbeat_supervisor.sv =====
// heartbeat_supervisor: per-node heartbeat consumer, master heartbeat timer
// and one pending request timeout. Uses hbs_pkg and hbs_ram.
// Sequence: a tick walks the node table through the shared add/sub unit, a
// ram read then an update per node, then master check, request ageing and
// flush; a heartbeat reads, evaluates, reports and flushes; a matching
// response reports and flushes; an issue is stored; output stalls hold these.
// Throughput: one item at a time; ready only while idle. Reset (synchronous,
// active low) clears node valid bits at once, so no clearing pass is needed.
module heartbeat_supervisor (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [hbs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [hbs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input items
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_command,
    input  logic [15:0]                     i_elapsed_ms,
    input  logic [6:0]                      i_node_id,
    input  logic [7:0]                      i_node_state,
    input  logic [15:0]                     i_object_index,
    input  logic [7:0]                      i_object_subindex,
    input  logic                            i_is_write,
    input  logic [15:0]                     i_time_to_live_ms,
    input  logic [31:0]                     i_abort_code,
    // result items
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [2:0]                      o_event_res,
    output logic [6:0]                      o_event_node,
    output logic [7:0]                      o_event_state,
    output logic [16:0]                     o_measured_interval_ms,
    output logic [31:0]                     o_result_code,
    output logic                            o_last
);
    import hbs_pkg::*;

    t_state r_state, n_state;

    // configuration registers
    logic [MS_W-1:0] r_interval, r_threshold;
    logic            r_inhibit;

    // captured item
    logic [MS_W-1:0]    r_elapsed;
    logic [ID_W-1:0]    r_node;
    logic [STATE_W-1:0] r_nstate;
    logic [15:0]        r_oidx;
    logic [7:0]         r_osub;
    logic               r_wr;
    logic [CODE_W-1:0]  r_abt;

    // pending request
    logic               r_req_pend;
    logic [ID_W-1:0]    r_req_node;
    logic [15:0]        r_req_idx;
    logic [7:0]         r_req_sub;
    logic               r_req_wr;
    logic [MS_W-1:0]    r_req_ttl, n_ttl;

    logic [MASTER_W-1:0] r_master, n_master;
    logic                r_alive [NUM_NODES];
    logic [NODE_W-1:0]   r_idx;

    // result staging: one held result plus the output register
    logic    r_pend_valid, r_out_valid, r_out_last;
    t_result r_pend, r_out;

    // node table ram
    logic               ram_re, ram_we;
    logic [NODE_W-1:0]  ram_raddr;
    logic [RAM_W-1:0]   ram_wdata, ram_rdata;
    logic [MS_W-1:0]    rd_timer;
    logic [STATE_W-1:0] rd_state;

    // shared add/sub unit
    logic [ALU_W-1:0] alu_a, alu_b, alu_res;
    logic             alu_sub, alu_zero;

    // sequencer control
    logic    in_acc, out_acc, out_free, can_push;
    logic    push, step_ok, flush_go;
    logic    alive_clr, alive_set, req_clr;
    logic    idx_last, node_ok, resp_match;
    t_result push_res;

    assign in_acc     = i_in_valid && o_in_ready;
    assign out_acc    = r_out_valid && i_out_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign can_push   = !r_pend_valid || out_free;
    assign o_in_ready = (r_state == S_IDLE);

    assign idx_last   = (r_idx == NODE_W'(NUM_NODES - 1));
    assign node_ok    = (r_node < ID_W'(NUM_NODES));
    assign resp_match = r_req_pend && (r_req_node == r_node) && (r_req_idx == r_oidx)
                        && (r_req_sub == r_osub) && (r_req_wr == r_wr);

    assign rd_timer = ram_rdata[RAM_W-1:STATE_W];
    assign rd_state = ram_rdata[STATE_W-1:0];

    assign alu_res  = alu_a + (alu_b ^ {ALU_W{alu_sub}}) + {{(ALU_W-1){1'b0}}, alu_sub};
    assign alu_zero = (alu_res == '0);

    hbs_ram #(
        .WIDTH (RAM_W),
        .DEPTH (NUM_NODES)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (t_cmd'(i_command))
                        CMD_TICK:      n_state = S_MADD;
                        CMD_HEARTBEAT: n_state = S_HB_RD;
                        CMD_RESPONSE:  n_state = S_RESP;
                        default:       n_state = S_IDLE;
                    endcase
                end
            end
            S_MADD:    n_state = S_RD;
            S_RD:      n_state = S_NODE;
            S_NODE: begin
                if (step_ok) begin
                    n_state = idx_last ? S_MCMP : S_RD;
                end
            end
            S_MCMP:    if (step_ok) n_state = S_REQ;
            S_REQ:     if (step_ok) n_state = S_FLUSH;
            S_HB_RD:   n_state = node_ok ? S_HB_EVAL : S_IDLE;
            S_HB_EVAL: if (step_ok) n_state = S_HB_SEEN;
            S_HB_SEEN: if (step_ok) n_state = S_FLUSH;
            S_RESP:    n_state = (resp_match && step_ok) ? S_FLUSH :
                                 (resp_match ? S_RESP : S_IDLE);
            S_FLUSH:   if (step_ok) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // datapath control and result generation
    always_comb begin
        alu_a     = '0;
        alu_b     = '0;
        alu_sub   = 1'b0;
        ram_re    = 1'b0;
        ram_we    = 1'b0;
        ram_raddr = r_idx;
        ram_wdata = ram_rdata;
        push      = 1'b0;
        push_res  = '0;
        step_ok   = 1'b1;
        flush_go  = 1'b0;
        alive_clr = 1'b0;
        alive_set = 1'b0;
        req_clr   = 1'b0;
        n_master  = r_master;
        n_ttl     = r_req_ttl;
        case (r_state)
            // master timer accumulates, saturating
            S_MADD: begin
                alu_a    = {1'b0, r_master};
                alu_b    = {3'b0, r_elapsed};
                n_master = alu_res[ALU_W-1] ? MASTER_MAX : alu_res[MASTER_W-1:0];
            end
            S_RD: begin
                ram_re = 1'b1;
            end
            // age one node, report if it runs out
            S_NODE: begin
                if (r_alive[r_idx]) begin
                    alu_a   = {3'b0, rd_timer};
                    alu_b   = {3'b0, r_elapsed};
                    alu_sub = 1'b1;
                    if (alu_res[ALU_W-1] || alu_zero) begin
                        push          = 1'b1;
                        push_res.evt  = EV_NODE_TIMEOUT;
                        push_res.node = ID_W'(r_idx);
                        step_ok       = can_push;
                        alive_clr     = can_push;
                    end else begin
                        ram_we    = 1'b1;
                        ram_wdata = {alu_res[MS_W-1:0], rd_state};
                    end
                end
            end
            // master heartbeat due check
            S_MCMP: begin
                alu_a   = {1'b0, r_master};
                alu_b   = {3'b0, r_interval};
                alu_sub = 1'b1;
                if (!alu_res[ALU_W-1]) begin
                    if (!r_inhibit) begin
                        push         = 1'b1;
                        push_res.evt = EV_MASTER_DUE;
                        step_ok      = can_push;
                    end
                    if (step_ok) begin
                        n_master = alu_res[MASTER_W-1:0];
                    end
                end
            end
            // pending request ageing
            S_REQ: begin
                if (r_req_pend) begin
                    alu_a   = {3'b0, r_req_ttl};
                    alu_b   = {3'b0, r_elapsed};
                    alu_sub = 1'b1;
                    if (alu_res[ALU_W-1] || alu_zero) begin
                        push          = 1'b1;
                        push_res.evt  = EV_REQ_TIMEOUT;
                        push_res.node = r_req_node;
                        step_ok       = can_push;
                        if (can_push) begin
                            n_ttl   = '0;
                            req_clr = 1'b1;
                        end
                    end else begin
                        n_ttl = alu_res[MS_W-1:0];
                    end
                end
            end
            S_HB_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_node[NODE_W-1:0];
            end
            // state change when inactive or a new state byte
            S_HB_EVAL: begin
                if (!r_alive[r_idx] || (rd_state != r_nstate)) begin
                    push          = 1'b1;
                    push_res.evt  = EV_STATE_CHANGE;
                    push_res.node = r_node;
                    push_res.st   = r_nstate;
                    step_ok       = can_push;
                end
            end
            // measured interval, then re-arm the node
            S_HB_SEEN: begin
                alu_a   = {3'b0, r_threshold};
                alu_b   = r_alive[r_idx] ? {3'b0, rd_timer} : {ALU_W{1'b1}};
                alu_sub = 1'b1;
                push          = 1'b1;
                push_res.evt  = EV_HB_SEEN;
                push_res.node = r_node;
                push_res.st   = r_nstate;
                push_res.ival = alu_res[ALU_W-1] ? '0 : alu_res[IVAL_W-1:0];
                step_ok       = can_push;
                if (can_push) begin
                    ram_we    = 1'b1;
                    ram_wdata = {r_threshold, r_nstate};
                    alive_set = 1'b1;
                end
            end
            S_RESP: begin
                if (resp_match) begin
                    push          = 1'b1;
                    push_res.evt  = EV_REQ_DONE;
                    push_res.node = r_node;
                    push_res.code = r_abt;
                    step_ok       = can_push;
                    req_clr       = can_push;
                end
            end
            // release the held result as the last one
            S_FLUSH: begin
                flush_go = r_pend_valid && out_free;
                step_ok  = !r_pend_valid || out_free;
            end
            default: begin
                step_ok = 1'b1;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_interval   <= RST_MASTER_INTERVAL;
            r_threshold  <= RST_ALIVE_THRESHOLD;
            r_inhibit    <= 1'b0;
            r_master     <= '0;
            r_req_pend   <= 1'b0;
            r_req_node   <= '0;
            r_req_idx    <= '0;
            r_req_sub    <= '0;
            r_req_wr     <= 1'b0;
            r_req_ttl    <= '0;
            r_idx        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < NUM_NODES; i++) begin
                r_alive[i] <= 1'b0;
            end
        end else begin
            r_state  <= n_state;
            r_master <= n_master;

            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MASTER_INTERVAL: r_interval  <= i_cfg_data;
                    CFG_ALIVE_THRESHOLD: r_threshold <= i_cfg_data;
                    CFG_INHIBIT_MASTER:  r_inhibit   <= i_cfg_data[0];
                    default:             r_inhibit   <= r_inhibit;
                endcase
            end

            // request store
            if (in_acc && (t_cmd'(i_command) == CMD_ISSUE)) begin
                r_req_pend <= 1'b1;
                r_req_node <= i_node_id;
                r_req_idx  <= i_object_index;
                r_req_sub  <= i_object_subindex;
                r_req_wr   <= i_is_write;
                r_req_ttl  <= i_time_to_live_ms;
            end else begin
                r_req_ttl <= n_ttl;
                if (req_clr) begin
                    r_req_pend <= 1'b0;
                end
            end

            // node walk index
            if (r_state == S_MADD) begin
                r_idx <= '0;
            end else if (r_state == S_NODE && step_ok && !idx_last) begin
                r_idx <= r_idx + 1'b1;
            end else if (r_state == S_HB_RD) begin
                r_idx <= r_node[NODE_W-1:0];
            end

            // node valid bits
            if (alive_clr) begin
                r_alive[r_idx] <= 1'b0;
            end else if (alive_set) begin
                r_alive[r_idx] <= 1'b1;
            end

            // result staging valids
            if (push && can_push) begin
                r_pend_valid <= 1'b1;
                if (r_pend_valid) begin
                    r_out_valid <= 1'b1;
                end else if (out_acc) begin
                    r_out_valid <= 1'b0;
                end
            end else if (flush_go) begin
                r_pend_valid <= 1'b0;
                r_out_valid  <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_elapsed <= i_elapsed_ms;
            r_node    <= i_node_id;
            r_nstate  <= i_node_state;
            r_oidx    <= i_object_index;
            r_osub    <= i_object_subindex;
            r_wr      <= i_is_write;
            r_abt     <= i_abort_code;
        end
        if (push && can_push) begin
            r_pend <= push_res;
            if (r_pend_valid) begin
                r_out      <= r_pend;
                r_out_last <= 1'b0;
            end
        end else if (flush_go) begin
            r_out      <= r_pend;
            r_out_last <= 1'b1;
        end
    end

    // outputs
    assign o_out_valid            = r_out_valid;
    assign o_event_res            = r_out.evt;
    assign o_event_node           = r_out.node;
    assign o_event_state          = r_out.st;
    assign o_measured_interval_ms = r_out.ival;
    assign o_result_code          = r_out.code;
    assign o_last                 = r_out_last;

    // a command with work keeps the block busy on the next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (t_cmd'(i_command) != CMD_ISSUE)) |=> !o_in_ready)
        else $error("block ready right after taking a tick, heartbeat or response");

    // nothing may be held back once the sequencer is idle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !r_pend_valid)
        else $error("result still held while idle");

    // after the last node a tick sequence hands over to the master check
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NODE && step_ok && idx_last) |=> (r_state == S_MCMP))
        else $error("node walk did not hand over to the master check");

    // last flag only set by the flush of a held result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        flush_go |=> (o_out_valid && o_last))
        else $error("flushed result not marked last");

endmodule
